/* src/annular_sector_pixel_test_assert.svh */
// assertion macros shared by the ring sector checker
`ifndef ANNULAR_SECTOR_PIXEL_TEST_ASSERT_SVH
`define ANNULAR_SECTOR_PIXEL_TEST_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define ASP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring sector pixel test: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define ASP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring sector pixel test: next-cycle check failed");

`endif

/* src/asp_pkg.sv */
// shared types and constants of the ring sector pixel test
package asp_pkg;

  localparam int COORD_W    = 12;
  localparam int DELTA_W    = 13;
  localparam int MAG_W      = 12;
  localparam int SQ_W       = 24;
  localparam int DIST_W     = 25;
  localparam int RAD_W      = 10;
  localparam int RSQ_W      = 20;
  localparam int QUOT_W     = 7;
  localparam int DIVIDEND_W = 19;
  localparam int ANGLE_W    = 10;
  localparam int ADDR_W     = 16;
  localparam int COLOUR_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int OCTANT_SPAN = 125;
  localparam int FULL_TURN   = 1000;

  // register index codes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_OUTER       = 3'd2,
    CFG_INNER       = 3'd3,
    CFG_SWEEP       = 3'd4,
    CFG_COLOUR      = 3'd5
  } cfg_idx_t;

  // shape settings seen by the geometry stages
  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RSQ_W-1:0]          outer_sq;
    logic [RSQ_W-1:0]          inner_sq;
    logic                      empty;
  } shape_t;

  // per-item flags that ride along with the divider
  typedef struct packed {
    logic [2:0]        oct;
    logic              in_ring;
    logic              on_screen;
    logic [ADDR_W-1:0] addr;
  } side_t;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] dividend;
    logic [MAG_W-1:0]      divisor;
    side_t                 side;
  } div_in_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    side_t             side;
  } div_out_t;

endpackage

/* src/asp_geom.sv */
// geometry stages: offsets, squared distance, ring test, octant and ratio operands
module asp_geom #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  asp_pkg::shape_t                    shape,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic signed [asp_pkg::COORD_W-1:0] pixel_x,
  input  logic signed [asp_pkg::COORD_W-1:0] pixel_y,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output asp_pkg::div_in_t                   dn_data
);

  localparam int AW = asp_pkg::ADDR_W + 7;
  localparam logic signed [asp_pkg::DELTA_W-1:0] WIDTH_S  =
    asp_pkg::DELTA_W'(SCREEN_WIDTH);
  localparam logic signed [asp_pkg::DELTA_W-1:0] HEIGHT_S =
    asp_pkg::DELTA_W'(SCREEN_HEIGHT);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: offsets from the centre, screen bounds, frame address
  logic signed [asp_pkg::DELTA_W-1:0] px_s, py_s;
  logic signed [asp_pkg::DELTA_W-1:0] dx_nxt, dy_nxt;
  logic signed [asp_pkg::DELTA_W-1:0] dx1_r, dy1_r;
  logic                               on1_nxt, on1_r;
  logic [AW-1:0]                      addr_full;
  logic [asp_pkg::ADDR_W-1:0]         addr1_r;

  always_comb begin
    px_s      = {pixel_x[asp_pkg::COORD_W-1], pixel_x};
    py_s      = {pixel_y[asp_pkg::COORD_W-1], pixel_y};
    dx_nxt    = px_s - {shape.center_x[asp_pkg::COORD_W-1], shape.center_x};
    dy_nxt    = py_s - {shape.center_y[asp_pkg::COORD_W-1], shape.center_y};
    on1_nxt   = !px_s[asp_pkg::DELTA_W-1] && !py_s[asp_pkg::DELTA_W-1] &&
                (px_s < WIDTH_S) && (py_s < HEIGHT_S);
    addr_full = AW'(pixel_y[asp_pkg::COORD_W-2:0]) * AW'(SCREEN_WIDTH) +
                AW'(pixel_x[asp_pkg::COORD_W-2:0]);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1_r   <= dx_nxt;
      dy1_r   <= dy_nxt;
      on1_r   <= on1_nxt;
      addr1_r <= addr_full[asp_pkg::ADDR_W-1:0];
    end
  end

  // stage 2: squares, magnitudes, octant choice with ratio operands
  logic [2*asp_pkg::DELTA_W-1:0] sqx_full, sqy_full;
  logic [asp_pkg::DELTA_W-1:0]   abx_full, aby_full;
  logic [asp_pkg::MAG_W-1:0]     ax, ay;
  logic [2:0]                    oct_nxt;
  logic [asp_pkg::MAG_W-1:0]     num_nxt, den_nxt;
  logic [asp_pkg::SQ_W-1:0]      sqx2_r, sqy2_r;
  logic [2:0]                    oct2_r;
  logic [asp_pkg::MAG_W-1:0]     num2_r, den2_r;
  logic                          on2_r;
  logic [asp_pkg::ADDR_W-1:0]    addr2_r;
  logic                          up_half, right_half;

  always_comb begin
    abx_full   = dx1_r[asp_pkg::DELTA_W-1] ? $unsigned(-dx1_r) : $unsigned(dx1_r);
    aby_full   = dy1_r[asp_pkg::DELTA_W-1] ? $unsigned(-dy1_r) : $unsigned(dy1_r);
    // squares taken on the magnitudes at full product width
    sqx_full   = (2*asp_pkg::DELTA_W)'(abx_full) * (2*asp_pkg::DELTA_W)'(abx_full);
    sqy_full   = (2*asp_pkg::DELTA_W)'(aby_full) * (2*asp_pkg::DELTA_W)'(aby_full);
    ax         = abx_full[asp_pkg::MAG_W-1:0];
    ay         = aby_full[asp_pkg::MAG_W-1:0];
    // screen y grows downward, so "up" is dy at or below zero
    up_half    = dy1_r[asp_pkg::DELTA_W-1] || (dy1_r == '0);
    right_half = !dx1_r[asp_pkg::DELTA_W-1];
    if (up_half && right_half) begin
      if (ax <= ay) begin
        oct_nxt = 3'd0; num_nxt = ax; den_nxt = ay;
      end else begin
        oct_nxt = 3'd1; num_nxt = ay; den_nxt = ax;
      end
    end else if (right_half) begin
      if (ax >= ay) begin
        oct_nxt = 3'd2; num_nxt = ay; den_nxt = ax;
      end else begin
        oct_nxt = 3'd3; num_nxt = ax; den_nxt = ay;
      end
    end else if (!up_half) begin
      if (ax <= ay) begin
        oct_nxt = 3'd4; num_nxt = ax; den_nxt = ay;
      end else begin
        oct_nxt = 3'd5; num_nxt = ay; den_nxt = ax;
      end
    end else begin
      if (ax >= ay) begin
        oct_nxt = 3'd6; num_nxt = ay; den_nxt = ax;
      end else begin
        oct_nxt = 3'd7; num_nxt = ax; den_nxt = ay;
      end
    end
    // the centre pixel has zero numerator; a unit divisor gives angle zero
    if (den_nxt == '0) den_nxt = asp_pkg::MAG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sqx2_r  <= sqx_full[asp_pkg::SQ_W-1:0];
      sqy2_r  <= sqy_full[asp_pkg::SQ_W-1:0];
      oct2_r  <= oct_nxt;
      num2_r  <= num_nxt;
      den2_r  <= den_nxt;
      on2_r   <= on1_r;
      addr2_r <= addr1_r;
    end
  end

  // stage 3: distance against the ring, scaled numerator
  logic [asp_pkg::DIST_W-1:0]     dist_sum;
  logic                           ring_nxt;
  logic [asp_pkg::DIVIDEND_W-1:0] n125;
  asp_pkg::div_in_t               out_nxt, out_r;

  always_comb begin
    dist_sum = asp_pkg::DIST_W'(sqx2_r) + asp_pkg::DIST_W'(sqy2_r);
    ring_nxt = !shape.empty &&
               (dist_sum <= asp_pkg::DIST_W'(shape.outer_sq)) &&
               (dist_sum >= asp_pkg::DIST_W'(shape.inner_sq));
    n125     = asp_pkg::DIVIDEND_W'(num2_r) *
               asp_pkg::DIVIDEND_W'(asp_pkg::OCTANT_SPAN);
    out_nxt.dividend       = n125;
    out_nxt.divisor        = den2_r;
    out_nxt.side.oct       = oct2_r;
    out_nxt.side.in_ring   = ring_nxt;
    out_nxt.side.on_screen = on2_r;
    out_nxt.side.addr      = addr2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) out_r <= out_nxt;
  end

  assign dn_data = out_r;

endmodule

/* src/asp_div.sv */
// pipelined restoring divider, one quotient bit per stage
module asp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  asp_pkg::div_in_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output asp_pkg::div_out_t dn_data
);

  localparam int QW = asp_pkg::QUOT_W;
  localparam int RW = asp_pkg::DIVIDEND_W;

  typedef struct packed {
    logic [RW-1:0]              rem;
    logic [asp_pkg::MAG_W-1:0]  den;
    logic [QW-1:0]              quot;
    asp_pkg::side_t             side;
  } div_st_t;

  div_st_t st_r [QW];
  logic    v_r  [QW];
  logic    rdy  [QW+1];

  assign rdy[QW] = dn_ready;

  // each stage settles quotient bit QW-1-j
  for (genvar j = 0; j < QW; j++) begin : g_stage
    div_st_t       prev, nxt;
    logic          prev_v;
    logic [RW-1:0] shifted;
    logic [RW:0]   trial;

    if (j == 0) begin : g_first
      assign prev.rem  = up_data.dividend;
      assign prev.den  = up_data.divisor;
      assign prev.quot = '0;
      assign prev.side = up_data.side;
      assign prev_v    = up_valid;
    end else begin : g_rest
      assign prev   = st_r[j-1];
      assign prev_v = v_r[j-1];
    end

    assign rdy[j] = !v_r[j] || rdy[j+1];

    always_comb begin
      shifted = RW'(prev.den) << (QW - 1 - j);
      trial   = {1'b0, prev.rem} - {1'b0, shifted};
      nxt     = prev;
      if (!trial[RW]) begin
        nxt.rem            = trial[RW-1:0];
        nxt.quot[QW-1-j]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_r[j] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) st_r[j] <= nxt;
    end
  end

  assign up_ready     = rdy[0];
  assign dn_valid     = v_r[QW-1];
  assign dn_data.quot = st_r[QW-1].quot;
  assign dn_data.side = st_r[QW-1].side;

endmodule

/* src/annular_sector_pixel_test.sv */
// Ring sector pixel test: one pixel coordinate in, one paint decision out. Items
// enter at one per clock while the output is not stalled and pass through three
// geometry stages (centre offset and screen bounds, squares and octant, ring test
// and numerator scaling), seven divider stages that each settle one bit of the
// in-octant ratio, and the output register that forms the pseudo-angle and the
// final hit. Every stage holds its item under backpressure, so empty stages still
// take new items while a result waits. Configuration writes pass through the config
// registers and, but for the colour, the derived shape registers before use.
module annular_sector_pixel_test #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [asp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [asp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] pixel_x, [23:12] pixel_y
  input  logic [23:0]                      in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] pixel_address, [31:16] pixel_colour
  output logic [31:0]                      out_tdata,
  // [0] write_enable
  output logic                             out_tuser
);

  // configuration registers
  logic signed [asp_pkg::COORD_W-1:0] center_x_r, center_y_r;
  logic [asp_pkg::RAD_W-1:0]          outer_r, inner_r, sweep_r;
  logic [asp_pkg::COLOUR_W-1:0]       colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      outer_r    <= '0;
      inner_r    <= '0;
      sweep_r    <= asp_pkg::RAD_W'(asp_pkg::FULL_TURN);
      colour_r   <= '0;
    end else if (cfg_we) begin
      case (asp_pkg::cfg_idx_t'(cfg_index))
        asp_pkg::CFG_CENTER_X: center_x_r <= cfg_wdata[asp_pkg::COORD_W-1:0];
        asp_pkg::CFG_CENTER_Y: center_y_r <= cfg_wdata[asp_pkg::COORD_W-1:0];
        asp_pkg::CFG_OUTER:    outer_r    <= cfg_wdata[asp_pkg::RAD_W-1:0];
        asp_pkg::CFG_INNER:    inner_r    <= cfg_wdata[asp_pkg::RAD_W-1:0];
        asp_pkg::CFG_SWEEP:    sweep_r    <= cfg_wdata[asp_pkg::RAD_W-1:0];
        asp_pkg::CFG_COLOUR:   colour_r   <= cfg_wdata[asp_pkg::COLOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // derived shape settings, recomputed from the registers every cycle
  asp_pkg::shape_t           shape_r;
  logic [asp_pkg::RAD_W-1:0] sweep_lim_r;

  always_ff @(posedge clk) begin
    shape_r.center_x <= center_x_r;
    shape_r.center_y <= center_y_r;
    shape_r.outer_sq <= asp_pkg::RSQ_W'(outer_r) * asp_pkg::RSQ_W'(outer_r);
    shape_r.inner_sq <= asp_pkg::RSQ_W'(inner_r) * asp_pkg::RSQ_W'(inner_r);
    shape_r.empty    <= (outer_r == '0) || (inner_r >= outer_r) || (sweep_r == '0);
    sweep_lim_r      <= (sweep_r > asp_pkg::RAD_W'(asp_pkg::FULL_TURN)) ?
                        asp_pkg::RAD_W'(asp_pkg::FULL_TURN) : sweep_r;
  end

  // geometry stages
  logic             geo_valid, geo_ready;
  asp_pkg::div_in_t geo_data;

  asp_geom #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .shape   (shape_r),
    .up_valid(in_tvalid),
    .up_ready(in_tready),
    .pixel_x (in_tdata[11:0]),
    .pixel_y (in_tdata[23:12]),
    .dn_valid(geo_valid),
    .dn_ready(geo_ready),
    .dn_data (geo_data)
  );

  // ratio divider
  logic              div_valid, div_ready;
  asp_pkg::div_out_t div_data;

  asp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(geo_valid),
    .up_ready(geo_ready),
    .up_data (geo_data),
    .dn_valid(div_valid),
    .dn_ready(div_ready),
    .dn_data (div_data)
  );

  // pseudo-angle, final hit decision and output register
  logic [asp_pkg::QUOT_W-1:0]  part;
  logic [asp_pkg::ANGLE_W-1:0] angle;
  logic                        hit_nxt;
  logic                        out_valid_r, hit_r;
  logic [asp_pkg::ADDR_W-1:0]  addr_r;
  logic [asp_pkg::COLOUR_W-1:0] colour_out_r;

  assign div_ready = !out_valid_r || out_tready;

  always_comb begin
    part    = div_data.side.oct[0] ?
              asp_pkg::QUOT_W'(asp_pkg::OCTANT_SPAN) - div_data.quot : div_data.quot;
    angle   = asp_pkg::ANGLE_W'(div_data.side.oct) *
              asp_pkg::ANGLE_W'(asp_pkg::OCTANT_SPAN) + asp_pkg::ANGLE_W'(part);
    hit_nxt = div_data.side.in_ring && div_data.side.on_screen &&
              (angle <= sweep_lim_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      hit_r        <= hit_nxt;
      addr_r       <= hit_nxt ? div_data.side.addr : '0;
      colour_out_r <= colour_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {colour_out_r, addr_r};
  assign out_tuser  = hit_r;

endmodule

/* src/asp_checker.sv */
// port-level checks for the ring sector pixel test, bound to the top level
`include "annular_sector_pixel_test_assert.svh"

module asp_checker #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  localparam int  PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam logic NO_WRAP  = (PIXELS <= 65536);

  // a miss carries a zero address
  `ASP_ASSERT_NOW(a_miss_addr_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[15:0] == 16'd0)

  // a hit lands inside the frame buffer
  `ASP_ASSERT_NOW(a_hit_in_frame, clk, rst_n, out_tvalid && out_tuser && NO_WRAP, 32'(out_tdata[15:0]) < 32'(PIXELS))

  // a stalled result holds
  `ASP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind annular_sector_pixel_test asp_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_asp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

/* sim/annular_sector_pixel_test_check.sv */
`timescale 1ns / 1ps
// channel monitor that predicts every ring sector paint decision and compares it
module annular_sector_pixel_test_check #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [11:0] pixel_x, [23:12] pixel_y
  input  logic [23:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] pixel_address, [31:16] pixel_colour
  input  logic [31:0]                    out_tdata,
  // [0] write_enable
  input  logic                           out_tuser,
  output int                             fail_count,
  output int                             pending,
  output int                             decided_count,
  output int                             painted_count
);

  localparam int MAX_REPORTS = 20;

  // octants clockwise from twelve o'clock, screen y pointing down
  typedef enum int {
    OCT_NNE, OCT_ENE, OCT_ESE, OCT_SSE, OCT_SSW, OCT_WSW, OCT_WNW, OCT_NNW
  } octant_t;

  typedef struct packed {
    logic                         we;
    logic [asp_pkg::ADDR_W-1:0]   addr;
    logic [asp_pkg::COLOUR_W-1:0] colour;
  } paint_t;

  // shadow copy of the shape registers
  logic signed [asp_pkg::COORD_W-1:0] ring_cx;
  logic signed [asp_pkg::COORD_W-1:0] ring_cy;
  logic [asp_pkg::RAD_W-1:0]          ring_outer;
  logic [asp_pkg::RAD_W-1:0]          ring_inner;
  logic [asp_pkg::RAD_W-1:0]          ring_sweep;
  logic [asp_pkg::COLOUR_W-1:0]       ring_colour;

  paint_t paint_queue[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    decided_count = 0;
    painted_count = 0;
  end

  // pseudo-angle in thousandths of a turn from the centre offset
  function automatic int sector_angle(int dx, int dy);
    int      up;
    int      ax;
    int      ay;
    int      num;
    int      den;
    int      part;
    octant_t oct;
    up = -dy;
    ax = (dx < 0) ? -dx : dx;
    ay = (up < 0) ? -up : up;
    if (ax == 0 && ay == 0) return 0;
    if (up >= 0 && dx >= 0) oct = (dx <= up) ? OCT_NNE : OCT_ENE;
    else if (up < 0 && dx >= 0) oct = (ax >= ay) ? OCT_ESE : OCT_SSE;
    else if (up < 0) oct = (ax <= ay) ? OCT_SSW : OCT_WSW;
    else oct = (ax >= ay) ? OCT_WNW : OCT_NNW;
    case (oct)
      OCT_NNE, OCT_SSE, OCT_SSW, OCT_NNW: begin
        num = ax;
        den = ay;
      end
      default: begin
        num = ay;
        den = ax;
      end
    endcase
    part = (num * asp_pkg::OCTANT_SPAN) / den;
    // odd octants count down toward the next axis
    if (int'(oct) % 2 == 1) part = asp_pkg::OCTANT_SPAN - part;
    return int'(oct) * asp_pkg::OCTANT_SPAN + part;
  endfunction

  // paint decision for one pixel under the current shape
  function automatic paint_t predict_paint(logic [23:0] pixel);
    int     px;
    int     py;
    int     dx;
    int     dy;
    int     dist_sq;
    int     sweep;
    logic   hit;
    paint_t res;
    px      = int'($signed(pixel[11:0]));
    py      = int'($signed(pixel[23:12]));
    dx      = px - int'(ring_cx);
    dy      = py - int'(ring_cy);
    dist_sq = dx * dx + dy * dy;
    sweep   = (int'(ring_sweep) > asp_pkg::FULL_TURN) ? asp_pkg::FULL_TURN : int'(ring_sweep);
    hit     = ring_outer != 0 && ring_inner < ring_outer && sweep != 0;
    if (hit && (dist_sq > int'(ring_outer) * int'(ring_outer) ||
                dist_sq < int'(ring_inner) * int'(ring_inner))) hit = 1'b0;
    if (hit && sector_angle(dx, dy) > sweep) hit = 1'b0;
    if (hit && (px < 0 || py < 0 || px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT)) hit = 1'b0;
    res.we     = hit;
    res.addr   = hit ? asp_pkg::ADDR_W'(py * SCREEN_WIDTH + px) : '0;
    res.colour = ring_colour;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (fail_count < MAX_REPORTS)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // register shadow, prediction on accepted items, compare on accepted results
  always @(posedge clk) begin : watch
    paint_t want;
    if (!rst_n) begin
      ring_cx     = '0;
      ring_cy     = '0;
      ring_outer  = '0;
      ring_inner  = '0;
      ring_sweep  = asp_pkg::RAD_W'(asp_pkg::FULL_TURN);
      ring_colour = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          asp_pkg::CFG_CENTER_X: ring_cx     = cfg_wdata[asp_pkg::COORD_W-1:0];
          asp_pkg::CFG_CENTER_Y: ring_cy     = cfg_wdata[asp_pkg::COORD_W-1:0];
          asp_pkg::CFG_OUTER:    ring_outer  = cfg_wdata[asp_pkg::RAD_W-1:0];
          asp_pkg::CFG_INNER:    ring_inner  = cfg_wdata[asp_pkg::RAD_W-1:0];
          asp_pkg::CFG_SWEEP:    ring_sweep  = cfg_wdata[asp_pkg::RAD_W-1:0];
          asp_pkg::CFG_COLOUR:   ring_colour = cfg_wdata[asp_pkg::COLOUR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) paint_queue.push_back(predict_paint(in_tdata));
      if (out_tvalid && out_tready) begin
        decided_count++;
        if (out_tuser) painted_count++;
        if (paint_queue.size() == 0) begin
          report_mismatch("result with no item waiting, write_enable", out_tuser, 0);
        end else begin
          want = paint_queue.pop_front();
          if (out_tuser !== want.we)
            report_mismatch("write_enable", out_tuser, want.we);
          if (out_tdata[15:0] !== want.addr)
            report_mismatch("pixel_address", out_tdata[15:0], want.addr);
          if (out_tdata[31:16] !== want.colour)
            report_mismatch("pixel_colour", out_tdata[31:16], want.colour);
        end
      end
    end
    pending = paint_queue.size();
  end

endmodule

/* sim/annular_sector_pixel_test_test.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the ring sector pixel test
module annular_sector_pixel_test_test;

  localparam int SCREEN_WIDTH     = 240;
  localparam int SCREEN_HEIGHT    = 240;
  localparam int RANDOM_PHASES    = 10;
  localparam int PHASE_ITEMS      = 190;
  localparam int LONG_HOLD_CYCLES = 150;
  // pipeline is 11 deep, so this covers any item still in flight
  localparam int DRAIN_PAUSE      = 16;
  // shape registers reach the datapath through the config and derived shape registers
  localparam int CFG_SETTLE       = 3;
  localparam int CYCLE_LIMIT      = 400000;

  // indexes with no register behind them
  localparam logic [asp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [asp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [asp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [23:0]                    in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [31:0]                    out_tdata;
  logic                           out_tuser;

  int fail_count;
  int pending;
  int decided_count;
  int painted_count;
  int shape_count;
  int cycle_count;

  logic idle_on;
  logic stall_on;
  logic long_hold;

  annular_sector_pixel_test #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  annular_sector_pixel_test_check #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .decided_count(decided_count),
    .painted_count(painted_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one pixel, optionally after an idle burst, and wait for acceptance
  task automatic offer_pixel(input int x, input int y);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {12'(y), 12'(x)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [asp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // drain the pipeline, then load a whole shape with junk in the unused upper bits
  task automatic load_shape(input int cx, input int cy, input int outer, input int inner,
                            input int sweep, input logic [15:0] colour);
    logic [15:0] junk;
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
    junk = 16'($urandom);
    write_reg(asp_pkg::CFG_CENTER_X, {junk[15:12], 12'(cx)});
    write_reg(asp_pkg::CFG_CENTER_Y, {junk[11:8], 12'(cy)});
    write_reg(asp_pkg::CFG_OUTER, {junk[15:10], 10'(outer)});
    write_reg(asp_pkg::CFG_INNER, {junk[9:4], 10'(inner)});
    write_reg(CFG_UNMAPPED_LO, 16'($urandom));
    write_reg(asp_pkg::CFG_SWEEP, {junk[5:0], 10'(sweep)});
    write_reg(CFG_UNMAPPED_HI, 16'($urandom));
    write_reg(asp_pkg::CFG_COLOUR, colour);
    cfg_we <= 1'b0;
    repeat (CFG_SETTLE) @(negedge clk);
    shape_count++;
  endtask

  // main stimulus
  initial begin
    int cx;
    int cy;
    int outer;
    int inner;
    int sweep;
    int reach;
    int x;
    int y;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    idle_on     = 1'b1;
    stall_on    = 1'b1;
    long_hold   = 1'b0;
    shape_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset shape has zero outer radius
    offer_pixel(5, 5);

    // ring around screen centre, sweep above a full turn
    load_shape(120, 120, 100, 20, 1023, 16'hFFFF);
    offer_pixel(120, 20);   // outer edge straight up
    offer_pixel(160, 40);
    offer_pixel(200, 80);
    offer_pixel(200, 160);
    offer_pixel(160, 200);
    offer_pixel(80, 200);
    offer_pixel(40, 160);
    offer_pixel(40, 80);
    offer_pixel(80, 40);
    offer_pixel(119, 21);   // just short of a full turn
    offer_pixel(120, 100);  // inner edge
    offer_pixel(120, 101);  // inside the hole
    offer_pixel(-2048, -2048);
    offer_pixel(2047, 2047);

    // full disc from the origin, centre pixel and screen corners
    load_shape(0, 0, 1023, 0, 1000, 16'h0001);
    offer_pixel(0, 0);
    offer_pixel(239, 239);
    offer_pixel(240, 5);
    offer_pixel(5, 240);

    // half turn, boundary exactly on the sweep
    load_shape(120, 120, 60, 0, 500, 16'hF800);
    offer_pixel(120, 170);
    offer_pixel(119, 170);

    // shapes that draw nothing: zero outer, inner at outer, zero sweep
    load_shape(120, 120, 0, 0, 1000, 16'h07E0);
    offer_pixel(120, 120);
    load_shape(120, 120, 60, 60, 1000, 16'h001F);
    offer_pixel(120, 60);
    load_shape(120, 120, 60, 0, 0, 16'h1234);
    offer_pixel(120, 60);

    // random rings, mostly pixels from the bounding box, some from anywhere
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          cx = -2048; cy = -2048; outer = 1023; inner = 0; sweep = 1023;
        end
        1: begin
          cx = 2047; cy = 2047; outer = 1023; inner = 1022; sweep = 1;
        end
        default: begin
          cx    = int'($urandom_range(0, 300)) - 30;
          cy    = int'($urandom_range(0, 300)) - 30;
          outer = int'($urandom_range(1, 160));
          if ($urandom_range(0, 5) == 0) inner = int'($urandom_range(outer, 1023));
          else inner = int'($urandom_range(0, outer - 1));
          case ($urandom_range(0, 9))
            0:       sweep = asp_pkg::FULL_TURN;
            1:       sweep = int'($urandom_range(asp_pkg::FULL_TURN + 1, 1023));
            default: sweep = int'($urandom_range(1, asp_pkg::FULL_TURN - 1));
          endcase
        end
      endcase
      load_shape(cx, cy, outer, inner, sweep, 16'($urandom));
      // final phase runs at full rate on both sides
      if (ph == RANDOM_PHASES - 1) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) long_hold = 1'b1;
        if ($urandom_range(0, 19) < 17) begin
          reach = outer + 3;
          x = cx + int'($urandom_range(0, 2 * reach)) - reach;
          y = cy + int'($urandom_range(0, 2 * reach)) - reach;
          x = (x < -2048) ? -2048 : (x > 2047) ? 2047 : x;
          y = (y < -2048) ? -2048 : (y > 2047) ? 2047 : y;
        end else begin
          x = int'($urandom_range(0, 4095)) - 2048;
          y = int'($urandom_range(0, 4095)) - 2048;
        end
        offer_pixel(x, y);
      end
    end

    // wait for the pipeline to empty, then a little longer for strays
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);

    $display("checked %0d pixel decisions over %0d shapes, %0d painted",
             decided_count, shape_count, painted_count);
    $display("directed edges, octants and empty shapes, random rings, one long output stall");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/asp_pkg.sv
src/asp_geom.sv
src/asp_div.sv
src/annular_sector_pixel_test.sv
src/asp_checker.sv
sim/annular_sector_pixel_test_check.sv
sim/annular_sector_pixel_test_test.sv
